// ===== rtl/core/bbrf_pkg.sv =====
package bbrf_pkg;

  // Default sizes of the ring and of the widest burst.
  localparam int DEPTH_DEFAULT     = 256;
  localparam int MAX_BURST_DEFAULT = 8;

  // Byte lanes on the data ports.
  localparam int LANES = 8;

  // Configuration register map.
  localparam int           REG_BUFFER_SIZE   = 0;
  localparam logic [8:0]   BUFFER_SIZE_RESET = 9'd256;

  // Request kinds.
  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISCARD = 3'd3,
    ACT_CLEAR   = 3'd4
  } act_t;

  // Result codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_TOO_FEW = 2'd2
  } stat_t;

  // Registered result handed from the control to the data assembly.
  typedef struct packed {
    logic             strobe;
    stat_t            status;
    logic [7:0]       fill_level;
    logic [7:0]       free_space;
    logic [7:0]       max_fill;
    logic [LANES-1:0] lane_mask;
  } result_t;

endpackage

// ===== rtl/core/burst_byte_ring_fifo.sv =====
// Byte ring FIFO moving bursts of up to MAX_BURST bytes per request.
//
// Requests: action, length and write_data are taken at a rising edge where
// start is high and busy is low. busy is high only while rst is asserted, so
// a request can be issued on every cycle. Each request gives exactly one
// result beat: done is high for one cycle, the cycle after the request, with
// status, read_data, fill_level, free_space and max_fill valid alongside it.
// Throughput is one request per cycle; the limit is the single registered
// read port of each byte bank, one bank per burst lane.
// The receiver cannot stall, so every result must be taken when shown.
//
// The ring size register sits at byte address 0 of the APB port; writing it
// also empties the ring but keeps the high-water mark. Writes are only to be
// made by the user while no request is in flight; the block does not enforce it.
//
// Reset clears both pointers and the high-water mark and sets the ring size
// to 256. Storage is not cleared; only bytes already written are ever read.
module burst_byte_ring_fifo #(
  parameter int DEPTH     = bbrf_pkg::DEPTH_DEFAULT,
  parameter int MAX_BURST = bbrf_pkg::MAX_BURST_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [3:0]  length,
  input  logic [63:0] write_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] read_data,
  output logic [7:0]  fill_level,
  output logic [7:0]  free_space,
  output logic [7:0]  max_fill,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(DEPTH);
  localparam int QW = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

  logic              accept;
  logic              cfg_hit;
  logic              cfg_wr;
  logic [8:0]        buffer_size;
  logic              bank_we    [MAX_BURST];
  logic [IW-1:0]     bank_waddr [MAX_BURST];
  logic [7:0]        bank_wdata [MAX_BURST];
  logic [IW-1:0]     bank_raddr [MAX_BURST];
  logic [7:0]        bank_rdata [MAX_BURST];
  bbrf_pkg::result_t res;
  logic [QW-1:0]     res_seq;

  // Request handshake.
  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration port: one register, word address taken from paddr[2].
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'(bbrf_pkg::REG_BUFFER_SIZE));
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? 32'(buffer_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= bbrf_pkg::BUFFER_SIZE_RESET;
    end else if (cfg_wr) begin
      buffer_size <= pwdata[8:0];
    end
  end

  bbrf_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .length      (length),
    .write_data  (write_data),
    .cfg_wr      (cfg_wr),
    .buffer_size (buffer_size),
    .bank_we     (bank_we),
    .bank_waddr  (bank_waddr),
    .bank_wdata  (bank_wdata),
    .bank_raddr  (bank_raddr),
    .res         (res),
    .res_seq     (res_seq)
  );

  // One byte bank per burst lane, each covering the whole ring.
  for (genvar b = 0; b < MAX_BURST; b++) begin : g_bank
    bbrf_bank #(
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata[b]),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Rotate bank outputs back into burst order and blank unused lanes.
  for (genvar i = 0; i < bbrf_pkg::LANES; i++) begin : g_lane
    if (i < MAX_BURST) begin : g_used
      logic [3:0] sel;
      always_comb begin
        sel = 4'(res_seq) + 4'(i);
        if (sel >= 4'(MAX_BURST)) begin
          sel = sel - 4'(MAX_BURST);
        end
        read_data[8*i +: 8] = res.lane_mask[i] ? bank_rdata[QW'(sel)] : 8'd0;
      end
    end else begin : g_unused
      assign read_data[8*i +: 8] = 8'd0;
    end
  end

  // Result beat.
  assign done       = res.strobe;
  assign status     = res.status;
  assign fill_level = res.fill_level;
  assign free_space = res.free_space;
  assign max_fill   = res.max_fill;

endmodule

// ===== rtl/core/bbrf_bank.sv =====
module bbrf_bank #(
  parameter int DEPTH = bbrf_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bbrf_ctrl.sv =====
module bbrf_ctrl #(
  parameter int  DEPTH     = bbrf_pkg::DEPTH_DEFAULT,
  parameter int  MAX_BURST = bbrf_pkg::MAX_BURST_DEFAULT,
  localparam int IW        = $clog2(DEPTH),
  localparam int QW        = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [2:0]          action,
  input  logic [3:0]          length,
  input  logic [63:0]         write_data,
  input  logic                cfg_wr,
  input  logic [8:0]          buffer_size,
  output logic                bank_we    [MAX_BURST],
  output logic [IW-1:0]       bank_waddr [MAX_BURST],
  output logic [7:0]          bank_wdata [MAX_BURST],
  output logic [IW-1:0]       bank_raddr [MAX_BURST],
  output bbrf_pkg::result_t   res,
  output logic [QW-1:0]       res_seq
);

  localparam int SW = $clog2(DEPTH + 1);

  // Ring pointers, bank phase of each pointer and the high-water mark.
  logic [IW-1:0] rd_idx, rd_idx_next;
  logic [IW-1:0] wr_idx, wr_idx_next;
  logic [QW-1:0] rd_seq, rd_seq_next;
  logic [QW-1:0] wr_seq, wr_seq_next;
  logic [7:0]    hw, hw_next;

  logic [SW-1:0]     rsize;
  logic [SW-1:0]     fill_cur, free_cur, fill_new, free_new;
  logic [3:0]        len_sat;
  logic              wr_ok, rd_ok;
  logic [31:0]       bs_ext, size_ext;
  bbrf_pkg::result_t res_next;

  // Ring offset with wrap at the ring size; a lane far past the end is parked at zero.
  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [3:0] off,
                                             logic [SW-1:0] sz);
    logic [31:0] sum;
    logic [31:0] sz32;
    sum  = 32'(base) + 32'(off);
    sz32 = 32'(sz);
    if (sum >= sz32) begin
      sum = sum - sz32;
    end
    if (sum >= sz32) begin
      sum = 32'd0;
    end
    return IW'(sum);
  endfunction

  // Burst lane served by a bank, given the bank phase of the pointer.
  function automatic logic [3:0] lane_of(int b, logic [QW-1:0] seq);
    logic [3:0] t;
    t = 4'(b) + 4'(MAX_BURST) - 4'(seq);
    if (t >= 4'(MAX_BURST)) begin
      t = t - 4'(MAX_BURST);
    end
    return t;
  endfunction

  // Bank phase advanced by a burst length.
  function automatic logic [QW-1:0] seq_add(logic [QW-1:0] seq, logic [3:0] len);
    logic [3:0] t;
    t = 4'(seq) + len;
    if (t >= 4'(MAX_BURST)) begin
      t = t - 4'(MAX_BURST);
    end
    return QW'(t);
  endfunction

  function automatic logic [7:0] sat8(logic [31:0] v);
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  // Ring size in force, limited to two up to the depth.
  always_comb begin
    bs_ext = 32'(buffer_size);
    if (bs_ext < 32'd2) begin
      size_ext = 32'd2;
    end else if (bs_ext > 32'(DEPTH)) begin
      size_ext = 32'(DEPTH);
    end else begin
      size_ext = bs_ext;
    end
    rsize = SW'(size_ext);
  end

  // Occupancy before the request and the checks on the burst length.
  always_comb begin
    if (wr_idx >= rd_idx) begin
      fill_cur = SW'(wr_idx) - SW'(rd_idx);
    end else begin
      fill_cur = rsize - SW'(rd_idx) + SW'(wr_idx);
    end
    free_cur = rsize - SW'(1) - fill_cur;
    len_sat  = (length > 4'(MAX_BURST)) ? 4'(MAX_BURST) : length;
    wr_ok    = 32'(len_sat) <= 32'(free_cur);
    rd_ok    = 32'(len_sat) <= 32'(fill_cur);
  end

  // Pointer updates and the result of the request.
  always_comb begin
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    rd_seq_next = rd_seq;
    wr_seq_next = wr_seq;
    hw_next     = hw;
    fill_new    = fill_cur;
    res_next    = '0;
    res_next.status = bbrf_pkg::ST_OK;

    if (cfg_wr) begin
      rd_idx_next = '0;
      wr_idx_next = '0;
      rd_seq_next = '0;
      wr_seq_next = '0;
    end else if (accept) begin
      case (action)
        bbrf_pkg::ACT_WRITE: begin
          if (!wr_ok) begin
            res_next.status = bbrf_pkg::ST_FULL;
          end else begin
            wr_idx_next = ring_add(wr_idx, len_sat, rsize);
            wr_seq_next = seq_add(wr_seq, len_sat);
            fill_new    = fill_cur + SW'(len_sat);
            if (sat8(32'(fill_new)) > hw) begin
              hw_next = sat8(32'(fill_new));
            end
          end
        end
        bbrf_pkg::ACT_READ, bbrf_pkg::ACT_PEEK, bbrf_pkg::ACT_DISCARD: begin
          if (!rd_ok) begin
            res_next.status = bbrf_pkg::ST_TOO_FEW;
          end else begin
            if (action != bbrf_pkg::ACT_PEEK) begin
              rd_idx_next = ring_add(rd_idx, len_sat, rsize);
              rd_seq_next = seq_add(rd_seq, len_sat);
              fill_new    = fill_cur - SW'(len_sat);
            end
            if (action != bbrf_pkg::ACT_DISCARD) begin
              res_next.lane_mask = 8'((9'd1 << len_sat) - 9'd1);
            end
          end
        end
        bbrf_pkg::ACT_CLEAR: begin
          rd_idx_next = '0;
          wr_idx_next = '0;
          rd_seq_next = '0;
          wr_seq_next = '0;
          fill_new    = '0;
        end
        default: begin
        end
      endcase
    end

    free_new            = rsize - SW'(1) - fill_new;
    res_next.strobe     = accept;
    res_next.fill_level = sat8(32'(fill_new));
    res_next.free_space = sat8(32'(free_new));
    res_next.max_fill   = hw_next;
  end

  // Bank addressing: each bank serves the burst lane that falls on its phase.
  for (genvar b = 0; b < MAX_BURST; b++) begin : g_bank_addr
    logic [3:0] wl, rl;
    always_comb begin
      wl            = lane_of(b, wr_seq);
      rl            = lane_of(b, rd_seq);
      bank_we[b]    = accept && !cfg_wr && (action == bbrf_pkg::ACT_WRITE) && wr_ok &&
                      (wl < len_sat);
      bank_waddr[b] = ring_add(wr_idx, wl, rsize);
      bank_wdata[b] = write_data[{wl[2:0], 3'b000} +: 8];
      bank_raddr[b] = ring_add(rd_idx, rl, rsize);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx     <= '0;
      wr_idx     <= '0;
      rd_seq     <= '0;
      wr_seq     <= '0;
      hw         <= '0;
      res.strobe <= 1'b0;
    end else begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      rd_seq <= rd_seq_next;
      wr_seq <= wr_seq_next;
      hw     <= hw_next;
      res    <= res_next;
    end
  end

  // Bank phase of the read pointer, registered alongside the bank read data.
  always_ff @(posedge clk) begin
    res_seq <= rd_seq;
  end

  // The ring never holds more than its usable capacity.
  assert property (@(posedge clk) disable iff (rst) 32'(fill_cur) < 32'(rsize))
    else $error("ring occupancy reached the ring size");

  // A refused write leaves the write pointer and the mark alone.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_wr && action == bbrf_pkg::ACT_WRITE && !wr_ok)
      |=> ($stable(wr_idx) && $stable(hw)))
    else $error("refused write changed state");

  // A peek does not move the read pointer.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_wr && action == bbrf_pkg::ACT_PEEK) |=> $stable(rd_idx))
    else $error("peek moved the read pointer");

  // Exactly one result beat follows each accepted request.
  assert property (@(posedge clk) disable iff (rst) accept |=> res.strobe)
    else $error("accepted request gave no result");
  assert property (@(posedge clk) disable iff (rst) !accept |=> !res.strobe)
    else $error("result without a request");

  // The high-water mark never falls.
  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> hw >= $past(hw))
    else $error("high-water mark fell");

endmodule
